@@ rtl/ektr_pkg.sv @@
// Package: shared types and constants for the encoder turbo key reporter.
package ektr_pkg;

    // Action codes
    localparam logic ACTION_POLL   = 1'b0;
    localparam logic ACTION_REPORT = 1'b1;

    // Mode codes; code 3 is never entered but is handled like normal
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_TOGGLE = 2'd1;
    localparam logic [1:0] MODE_FIRE   = 2'd2;

    localparam logic [7:0]  DEBOUNCE_RESET = 8'd10;
    localparam logic [14:0] PLAIN_MASK     = 15'h07FF;
    localparam logic [14:0] ARROW_MASK     = 15'h7800;
    localparam logic [15:0] DELAY_MAX      = 16'hFFFF;

    typedef struct packed {
        logic        action;
        logic [15:0] encoder_count;
        logic        knob_pressed;
        logic [14:0] key_levels;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [14:0] report;
        logic [15:0] delay_value;
        logic [1:0]  mode_value;
        logic        redraw;
    } result_t;

endpackage

@@ rtl/ektr_core.sv @@
// Core: persistent encoder, mode and timing state plus per-beat result logic.
module ektr_core
    import ektr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  debounce_polls,
    input  item_t       item,
    output result_t     result
);

    logic [15:0] previous_count_reg, previous_count_next;
    logic [15:0] delay_ms_reg, delay_ms_next;
    logic [7:0]  release_count_reg, release_count_next;
    logic [1:0]  mode_reg, mode_next;
    logic [31:0] last_fire_time_reg, last_fire_time_next;
    logic [31:0] last_toggle_time_reg, last_toggle_time_next;
    logic        toggle_phase_reg, toggle_phase_next;

    logic [15:0] change;
    logic [17:0] sum;
    logic [31:0] fire_elapsed;
    logic [14:0] arrows;

    // Compute next state and the result for the beat in the input register
    always_comb
    begin
        previous_count_next   = previous_count_reg;
        delay_ms_next         = delay_ms_reg;
        release_count_next    = release_count_reg;
        mode_next             = mode_reg;
        last_fire_time_next   = last_fire_time_reg;
        last_toggle_time_next = last_toggle_time_reg;
        toggle_phase_next     = toggle_phase_reg;
        result                = '0;

        change       = item.encoder_count - previous_count_reg;
        sum          = {2'b00, delay_ms_reg} + {{2{change[15]}}, change};
        fire_elapsed = item.now_ms - last_fire_time_reg;
        arrows       = item.key_levels & ARROW_MASK;

        unique case (item.action)
            ACTION_POLL:
            begin
                previous_count_next = item.encoder_count;
                // Clamp at zero, saturate at the top
                if (sum[17])
                    delay_ms_next = '0;
                else if (sum[16])
                    delay_ms_next = DELAY_MAX;
                else
                    delay_ms_next = sum[15:0];
                result.redraw = (delay_ms_next != delay_ms_reg);

                // Debounced knob press steps the mode
                if (item.knob_pressed)
                begin
                    if (release_count_reg >= debounce_polls)
                    begin
                        release_count_next = '0;
                        mode_next = (mode_reg <= MODE_TOGGLE) ? mode_reg + 2'd1 : MODE_NORMAL;
                        result.redraw = 1'b1;
                    end
                end
                else if (release_count_reg < debounce_polls)
                begin
                    release_count_next = release_count_reg + 8'd1;
                end
            end
            ACTION_REPORT:
            begin
                result.report = item.key_levels & PLAIN_MASK;
                priority if (mode_reg == MODE_TOGGLE)
                begin
                    if (item.now_ms != last_toggle_time_reg)
                    begin
                        toggle_phase_next     = !toggle_phase_reg;
                        last_toggle_time_next = item.now_ms;
                    end
                    if (!toggle_phase_next)
                        result.report = result.report | arrows;
                end
                else if (mode_reg == MODE_FIRE)
                begin
                    if (fire_elapsed >= {16'd0, delay_ms_reg})
                    begin
                        last_fire_time_next = item.now_ms;
                        result.report = result.report | arrows;
                    end
                end
                else
                begin
                    mode_next     = MODE_NORMAL;
                    result.report = result.report | arrows;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase

        result.delay_value = delay_ms_next;
        result.mode_value  = mode_next;
    end

    // Commit state when the beat moves to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_count_reg   <= '0;
            delay_ms_reg         <= '0;
            release_count_reg    <= '0;
            mode_reg             <= MODE_NORMAL;
            last_fire_time_reg   <= '0;
            last_toggle_time_reg <= '0;
            toggle_phase_reg     <= 1'b0;
        end
        else if (advance)
        begin
            previous_count_reg   <= previous_count_next;
            delay_ms_reg         <= delay_ms_next;
            release_count_reg    <= release_count_next;
            mode_reg             <= mode_next;
            last_fire_time_reg   <= last_fire_time_next;
            last_toggle_time_reg <= last_toggle_time_next;
            toggle_phase_reg     <= toggle_phase_next;
        end
    end

endmodule

@@ rtl/encoder_turbo_key_reporter.sv @@
// Top level: input register, core logic, output register, debounce setting.
// A beat in the input register goes via the core logic to the output register.
// Throughput: one beat per cycle without result_stall; each register holds
// one beat, so input is taken while a result waits behind result_stall.
// Reset (rst_n low, asynchronous): all state zero, mode normal, both
// registers empty, debounce setting back to 10.
module encoder_turbo_key_reporter
    import ektr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    logic [7:0] debounce_reg;
    logic       advance;
    logic       in_take;
    result_t    core_result;

    // Move a beat forward when the output register is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign in_take    = item_valid && !item_stall;

    ektr_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .debounce_polls (debounce_reg),
        .item           (in_item_reg),
        .result         (core_result)
    );

    // Hold the debounce setting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_reg <= DEBOUNCE_RESET;
        else if (cfg_wr_en)
            debounce_reg <= cfg_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= item;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= core_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

endmodule
